// ----- rtl/ohr_pkg.sv -----
// ----------------------------------------------------------------------------
// ohr_pkg: shared types and constants of the overwriting history ring
// Holds the entry, transaction and cell control types, the operation and
// status codes, and the sizes of the history store.
// ----------------------------------------------------------------------------
package ohr_pkg;

    // Sizes of the history store.
    localparam int DEPTH      = 32;
    localparam int DATA_WIDTH = 32;
    localparam int ID_W       = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Operation codes carried in the kind field.
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_FIND  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // Status codes of a result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;

    // One stored history entry.
    typedef struct packed {
        logic [ID_W-1:0]       id;
        logic [DATA_WIDTH-1:0] data;
    } entry_t;

    // Request transaction.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] payload;
        logic [7:0]  age_index;
        logic [31:0] wanted_id;
    } req_t;

    // Response transaction.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] record_id;
        logic [31:0] record_data;
        logic [8:0]  held_count;
        logic [31:0] overwrites;
    } rsp_t;

    // Control shared by every cell of the chain.
    typedef struct packed {
        logic shift;
        logic find;
        logic read;
    } cell_ctrl_t;

endpackage

// ----- rtl/overwrite_history_ring.sv -----
// ----------------------------------------------------------------------------
// overwrite_history_ring: fixed-depth history that overwrites its oldest entry
// Top level: chain of entry cells, counters and the response register.
// ----------------------------------------------------------------------------
// Usage:
// A request transaction on req (valid/stall) carries an add, a read by age,
// a find by id or a clear. Each request gives exactly one response
// transaction on rsp, in the cycle after it is accepted.
// Entries sit in a chain of cells with the newest in cell 0; an add shifts
// the chain by one place, so the oldest entry falls off the end once full.
// Reads and finds compare in every cell at once and pick the newest hit,
// so one request is taken per cycle while req_stall is low; the per-cell
// compare and the newest-first pick feed the response register.
// The response sits in an output register. While it waits under rsp_stall
// the block stalls req; otherwise a new request can enter every cycle.
// Reset clears the count, the overwrite total and the response valid, and
// sets the next record id to one. Stored entries are not cleared; cells
// beyond the count never take part in a read or a find.
// ----------------------------------------------------------------------------
module overwrite_history_ring
    import ohr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic             rsp_valid_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [ID_W-1:0]  next_id_reg;
    logic [ID_W-1:0]  next_id_next;
    logic [31:0]      overwrite_reg;
    logic [31:0]      overwrite_next;

    logic             accept;
    cell_ctrl_t       ctrl;
    entry_t           new_entry;
    entry_t           cell_entry [DEPTH];
    logic [DEPTH-1:0] cell_hit;
    logic             found;
    entry_t           chosen;

    // A waiting response holds back the next request.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    // Control common to all cells.
    always_comb
    begin
        ctrl.shift = accept && (req.kind == KIND_ADD);
        ctrl.find  = req.kind == KIND_FIND;
        ctrl.read  = req.kind == KIND_READ;
        new_entry.id   = next_id_reg;
        new_entry.data = req.payload[DATA_WIDTH-1:0];
    end

    // Chain of cells, newest entry in cell 0.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t prev;

        if (i == 0)
        begin : g_head
            assign prev = new_entry;
        end
        else
        begin : g_link
            assign prev = cell_entry[i-1];
        end

        ohr_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (CNT_W'(i) < count_reg),
            .read_sel   (req.age_index == 8'(i)),
            .wanted_id  (req.wanted_id),
            .prev_entry (prev),
            .entry      (cell_entry[i]),
            .hit        (cell_hit[i])
        );
    end

    ohr_pick u_pick (
        .hits    (cell_hit),
        .entries (cell_entry),
        .found   (found),
        .chosen  (chosen)
    );

    // Next state of the counters and the response for this transaction.
    always_comb
    begin
        count_next     = count_reg;
        next_id_next   = next_id_reg;
        overwrite_next = overwrite_reg;
        rsp_next       = '0;
        unique case (req.kind)
            KIND_ADD:
            begin
                next_id_next       = next_id_reg + ID_W'(1);
                rsp_next.record_id = next_id_reg;
                if (count_reg == CNT_W'(DEPTH))
                begin
                    overwrite_next = overwrite_reg + 32'd1;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_READ, KIND_FIND:
            begin
                if ((req.kind == KIND_READ) && (count_reg == '0))
                begin
                    rsp_next.status = ST_EMPTY;
                end
                else if (found)
                begin
                    rsp_next.status      = ST_OK;
                    rsp_next.record_id   = chosen.id;
                    rsp_next.record_data = 32'(chosen.data);
                end
                else
                begin
                    rsp_next.status = ST_MISS;
                end
            end
            KIND_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        rsp_next.held_count = 9'(count_next);
        rsp_next.overwrites = overwrite_next;
    end

    // Control state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
            next_id_reg   <= ID_W'(1);
            overwrite_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
                count_reg     <= count_next;
                next_id_reg   <= next_id_next;
                overwrite_reg <= overwrite_next;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The count never passes the depth of the store.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("history count beyond depth");

    // An add to a full store bumps the overwrite total by one.
    a_overwrite_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.kind == KIND_ADD) && (count_reg == CNT_W'(DEPTH))
        |=> (overwrite_reg == $past(overwrite_reg) + 32'd1))
        else $error("overwrite total did not advance");

    // An empty status always reports an empty store.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_reg.status == ST_EMPTY) |-> (rsp_reg.held_count == 9'd0))
        else $error("empty status with entries held");

    // Every accepted request leaves a response waiting.
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("response missing after request");

endmodule

// ----- rtl/ohr_cell.sv -----
// ----------------------------------------------------------------------------
// ohr_cell: one slot of the history chain
// Holds one entry, takes its neighbour's entry when a new record is added,
// and flags a hit for a read by age or a find by id.
// ----------------------------------------------------------------------------
module ohr_cell
    import ohr_pkg::*;
(
    input  logic            clk,
    input  cell_ctrl_t      ctrl,
    input  logic            occupied,
    input  logic            read_sel,
    input  logic [ID_W-1:0] wanted_id,
    input  entry_t          prev_entry,
    output entry_t          entry,
    output logic            hit
);

    entry_t entry_reg;

    // The entry moves one place older on every add.
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            entry_reg <= prev_entry;
        end
    end

    // A hit needs a live entry and either a matching id or the selected age.
    always_comb
    begin
        hit = occupied && ((ctrl.find && (entry_reg.id == wanted_id)) ||
                           (ctrl.read && read_sel));
    end

    assign entry = entry_reg;

endmodule

// ----- rtl/ohr_pick.sv -----
// ----------------------------------------------------------------------------
// ohr_pick: newest-first selection over the cell chain
// Keeps the hit of the lowest cell, which is the newest entry, and returns
// that cell's entry together with a found flag.
// ----------------------------------------------------------------------------
module ohr_pick
    import ohr_pkg::*;
(
    input  logic [DEPTH-1:0] hits,
    input  entry_t           entries [DEPTH],
    output logic             found,
    output entry_t           chosen
);

    localparam int ENTRY_W = $bits(entry_t);

    logic [DEPTH-1:0]   first_hit;
    logic [ENTRY_W-1:0] acc;

    // Isolate the lowest set bit, then gather that cell with an AND-OR mux.
    always_comb
    begin
        first_hit = hits & (~hits + DEPTH'(1));
        acc       = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            acc = acc | (entries[i] & {ENTRY_W{first_hit[i]}});
        end
        found  = |hits;
        chosen = acc;
    end

endmodule
